[hw/rtl/sfov_pkg.sv]
package sfov_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       see_through;
  } in_word_t;

  typedef struct packed {
    logic visible;
    logic cell_open;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLR_ALL,
    ST_IDLE,
    ST_RESP,
    ST_CLR_SEEN,
    ST_OCT_INIT,
    ST_STEP,
    ST_CELL,
    ST_POP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_all;
    logic oct_init;
    logic step;
    logic visit;
    logic pop;
    logic fin;
    logic load;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic sweep_last;
    logic row_end;
    logic pop;
    logic sp_one;
    logic oct_last;
    logic cell_in;
    logic out_full;
  } status_t;

  localparam logic [4:0] RADIUS_RESET = 5'd8;

  // octant transform: x = dx*XX + dy*XY, y = dx*YX + dy*YY
  localparam logic signed [1:0] OCT_XX [8] =
    '{2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1};
  localparam logic signed [1:0] OCT_XY [8] =
    '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0};
  localparam logic signed [1:0] OCT_YX [8] =
    '{2'sd0, 2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0};
  localparam logic signed [1:0] OCT_YY [8] =
    '{2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1};

endpackage

[hw/rtl/shadowcast_field_of_view_core.sv]
// Cell write, cell read and no-op words pass through ST_IDLE and ST_RESP; the result uses
// the registered read of the cell maps, and no new word is taken until it is loaded.
// Compute word: clears the visibility map; per octant it starts a scan, steps past
// row ends and off-map cells, visits in-map cells, pops saved scans; then finishes.
// Reset: synchronous, active low; afterwards a clearing pass over all
// MAP_WIDTH*MAP_HEIGHT cells of both maps runs with the input stalled. Radius resets to 8.
module shadowcast_field_of_view_core #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64,
  parameter int MAX_RADIUS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfov_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sfov_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  sfov_pkg::cmd_t    cmd;
  sfov_pkg::status_t status;

  sfov_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfov_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[hw/rtl/sfov_ctrl.sv]
module sfov_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfov_pkg::status_t  status,
  output sfov_pkg::cmd_t     cmd
);

  sfov_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfov_pkg::ST_CLR_ALL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != sfov_pkg::ST_IDLE);
    unique case (state_r)
      sfov_pkg::ST_CLR_ALL: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_all = 1'b1;
        if (status.sweep_last) state_nxt = sfov_pkg::ST_IDLE;
      end
      sfov_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (status.in_op == sfov_pkg::OP_COMPUTE) ?
                       sfov_pkg::ST_CLR_SEEN : sfov_pkg::ST_RESP;
        end
      end
      sfov_pkg::ST_RESP: begin
        if (!status.out_full) begin
          cmd.load  = 1'b1;
          state_nxt = sfov_pkg::ST_IDLE;
        end
      end
      sfov_pkg::ST_CLR_SEEN: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_nxt = sfov_pkg::ST_OCT_INIT;
      end
      sfov_pkg::ST_OCT_INIT: begin
        cmd.oct_init = 1'b1;
        state_nxt    = sfov_pkg::ST_STEP;
      end
      sfov_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        priority if (status.row_end && status.pop && status.sp_one) begin
          state_nxt = status.oct_last ? sfov_pkg::ST_FIN : sfov_pkg::ST_OCT_INIT;
        end else if (status.row_end && status.pop) begin
          state_nxt = sfov_pkg::ST_POP;
        end else if (!status.row_end && status.cell_in) begin
          state_nxt = sfov_pkg::ST_CELL;
        end else begin
          state_nxt = sfov_pkg::ST_STEP;
        end
      end
      sfov_pkg::ST_CELL: begin
        cmd.visit = 1'b1;
        state_nxt = sfov_pkg::ST_STEP;
      end
      sfov_pkg::ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = sfov_pkg::ST_STEP;
      end
      sfov_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sfov_pkg::ST_RESP;
      end
      default: state_nxt = sfov_pkg::ST_CLR_ALL;
    endcase
  end

endmodule

[hw/rtl/sfov_dp.sv]
module sfov_dp #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64,
  parameter int MAX_RADIUS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfov_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sfov_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  sfov_pkg::cmd_t      cmd,
  output sfov_pkg::status_t   status
);

  localparam int NCELL = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(NCELL);
  localparam int RW    = $clog2(MAX_RADIUS + 2);
  localparam int SW    = RW + 3;
  localparam int CW    = ((RW > 8) ? RW : 8) + 2;
  localparam int DW    = 2 * RW + 1;
  localparam int SPW   = $clog2(MAX_RADIUS + 1);
  localparam int SPI   = $clog2(MAX_RADIUS);

  typedef struct packed {
    logic [RW-1:0]        row;
    logic signed [RW:0]   dx;
    logic signed [SW-1:0] sn;
    logic signed [SW-1:0] sd;
    logic signed [SW-1:0] en;
    logic signed [SW-1:0] ed;
    logic signed [SW-1:0] nn;
    logic signed [SW-1:0] nd;
    logic                 blocked;
  } frame_t;

  function automatic logic signed [CW-1:0] oct_term(logic signed [1:0] c,
                                                    logic signed [RW:0] v);
    logic signed [CW-1:0] r;
    unique case (c)
      2'sd1:   r = CW'(v);
      -2'sd1:  r = -CW'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic in_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    return (x >= 0) && (y >= 0) && (x < MAP_WIDTH) && (y < MAP_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] x,
                                              logic signed [CW-1:0] y);
    return AW'($unsigned(y)) * AW'(MAP_WIDTH) + AW'($unsigned(x));
  endfunction

  logic                   clear_mem [NCELL];
  logic                   seen_mem  [NCELL];
  frame_t                 stk_mem   [MAX_RADIUS];

  logic [4:0]             rad_cfg_r;
  logic [RW-1:0]          rad;
  sfov_pkg::in_word_t     item_r;
  logic                   item_in_r;
  logic [AW-1:0]          item_addr_r;
  logic [AW-1:0]          clr_r, clr_nxt;
  frame_t                 f_r, f_nxt, stk_rd_r, stk_wd, new_f;
  logic                   stk_we;
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic [2:0]             oct_r, oct_nxt;
  logic [AW-1:0]          addr_r;
  logic signed [SW-1:0]   ln_r, ld_r, rn_r, rd_r;
  logic                   dist_ok_r;
  logic                   clear_q, seen_q;
  logic                   out_valid_r;
  sfov_pkg::out_word_t    out_word_r;

  logic signed [CW-1:0]   in_x, in_y, cx, cy, px, py;
  logic                   in_in;
  logic [AW-1:0]          in_addr, px_addr, rd_a;
  logic signed [RW:0]     dy;
  logic signed [SW-1:0]   dxw, rowv, ln_c, ld_c, rn_c, rd_c;
  logic [RW-1:0]          mag, row1;
  logic                   dist_ok_c, sweep_last;
  logic signed [2*SW-1:0] p1, p2, p3, p4, p5, p6;
  logic                   seen_we, seen_wd, clear_we, clear_wd;
  logic [AW-1:0]          seen_wa, clear_wa;

  assign rad = (rad_cfg_r > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_cfg_r);

  assign in_x    = $signed(CW'(in_word.cell_x));
  assign in_y    = $signed(CW'(in_word.cell_y));
  assign in_in   = in_map(in_x, in_y);
  assign in_addr = cell_addr(in_x, in_y);

  // cell geometry for the current frame position
  assign cx      = $signed(CW'(item_r.cell_x));
  assign cy      = $signed(CW'(item_r.cell_y));
  assign dy      = -$signed({1'b0, f_r.row});
  assign px      = cx + oct_term(sfov_pkg::OCT_XX[oct_r], f_r.dx)
                      + oct_term(sfov_pkg::OCT_XY[oct_r], dy);
  assign py      = cy + oct_term(sfov_pkg::OCT_YX[oct_r], f_r.dx)
                      + oct_term(sfov_pkg::OCT_YY[oct_r], dy);
  assign px_addr = cell_addr(px, py);
  assign dxw     = SW'(f_r.dx);
  assign rowv    = $signed(SW'(f_r.row));
  assign ln_c    = SW'(1) - (dxw <<< 1);
  assign ld_c    = (rowv <<< 1) - SW'(1);
  assign rn_c    = -(dxw <<< 1) - SW'(1);
  assign rd_c    = (rowv <<< 1) + SW'(1);
  assign mag     = RW'($unsigned(-f_r.dx));
  assign dist_ok_c = (DW'(mag) * DW'(mag) + DW'(f_r.row) * DW'(f_r.row))
                     <= (DW'(rad) * DW'(rad));

  // slope compares, ratios cross-multiplied
  assign p1 = f_r.sn * rd_r;
  assign p2 = rn_r * f_r.sd;
  assign p3 = f_r.en * ld_r;
  assign p4 = ln_r * f_r.ed;
  assign p5 = f_r.sn * ld_r;
  assign p6 = ln_r * f_r.sd;

  assign row1       = f_r.row + 1'b1;
  assign sweep_last = (clr_r == AW'(NCELL - 1));

  always_comb begin
    new_f         = f_r;
    new_f.row     = row1;
    new_f.dx      = -$signed({1'b0, row1});
    new_f.en      = ln_r;
    new_f.ed      = ld_r;
    new_f.nn      = '0;
    new_f.nd      = SW'(1);
    new_f.blocked = 1'b0;
  end

  always_comb begin
    f_nxt    = f_r;
    sp_nxt   = sp_r;
    oct_nxt  = oct_r;
    stk_we   = 1'b0;
    stk_wd   = f_r;
    seen_we  = 1'b0;
    seen_wa  = item_addr_r;
    seen_wd  = 1'b1;
    clear_we = 1'b0;
    clear_wa = in_addr;
    clear_wd = in_word.see_through;
    clr_nxt  = clr_r;

    if (cmd.sweep) begin
      seen_we  = 1'b1;
      seen_wa  = clr_r;
      seen_wd  = 1'b0;
      clear_we = cmd.sweep_all;
      clear_wa = clr_r;
      clear_wd = 1'b0;
      clr_nxt  = sweep_last ? '0 : clr_r + 1'b1;
    end
    if (cmd.accept && in_word.opcode == sfov_pkg::OP_WRITE && in_in) begin
      clear_we = 1'b1;
    end
    if (cmd.oct_init) begin
      f_nxt.row     = RW'(1);
      f_nxt.dx      = -$signed((RW + 1)'(1));
      f_nxt.sn      = SW'(1);
      f_nxt.sd      = SW'(1);
      f_nxt.en      = '0;
      f_nxt.ed      = SW'(1);
      f_nxt.nn      = '0;
      f_nxt.nd      = SW'(1);
      f_nxt.blocked = 1'b0;
      sp_nxt        = SPW'(1);
    end
    if (cmd.step) begin
      if (f_r.dx > 0) begin
        if (f_r.blocked || f_r.row >= rad) begin
          if (sp_r == SPW'(1)) oct_nxt = oct_r + 1'b1;
        end else begin
          f_nxt.row     = row1;
          f_nxt.dx      = -$signed({1'b0, row1});
          f_nxt.blocked = 1'b0;
        end
      end else begin
        f_nxt.dx = f_r.dx + 1'b1;
      end
    end
    if (cmd.visit && !(p1 < p2)) begin
      if (p3 > p4) begin
        f_nxt.dx = (RW + 1)'(1);
      end else begin
        seen_we = dist_ok_r;
        seen_wa = addr_r;
        if (f_r.blocked) begin
          if (!clear_q) begin
            f_nxt.nn = rn_r;
            f_nxt.nd = rd_r;
          end else begin
            f_nxt.blocked = 1'b0;
            f_nxt.sn      = f_r.nn;
            f_nxt.sd      = f_r.nd;
          end
        end else if (!clear_q && f_r.row < rad) begin
          f_nxt.blocked = 1'b1;
          f_nxt.nn      = rn_r;
          f_nxt.nd      = rd_r;
          if (!(p5 < p6) && sp_r < MAX_RADIUS) begin
            stk_we = 1'b1;
            stk_wd = f_nxt;
            f_nxt  = new_f;
            sp_nxt = sp_r + 1'b1;
          end
        end
      end
    end
    if (cmd.pop) begin
      f_nxt  = stk_rd_r;
      sp_nxt = sp_r - 1'b1;
    end
    if (cmd.fin) begin
      seen_we = item_in_r;
      seen_wa = item_addr_r;
    end
  end

  always_comb begin
    priority if (cmd.accept) rd_a = in_addr;
    else if (cmd.step)       rd_a = px_addr;
    else                     rd_a = item_addr_r;
  end

  always_ff @(posedge clk) begin
    if (clear_we) clear_mem[clear_wa] <= clear_wd;
    if (seen_we)  seen_mem[seen_wa]   <= seen_wd;
    clear_q <= clear_mem[rd_a];
    seen_q  <= seen_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[SPI'(sp_r - 1'b1)] <= stk_wd;
    stk_rd_r <= stk_mem[SPI'(sp_r - SPW'(2))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_cfg_r   <= sfov_pkg::RADIUS_RESET;
      clr_r       <= '0;
      sp_r        <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rad_cfg_r <= cfg_wdata;
      clr_r <= clr_nxt;
      sp_r  <= sp_nxt;
      oct_r <= cmd.accept ? 3'd0 : oct_nxt;
      if (cmd.load)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    if (cmd.accept) begin
      item_r      <= in_word;
      item_in_r   <= in_in;
      item_addr_r <= in_addr;
    end
    if (cmd.step) begin
      addr_r    <= px_addr;
      ln_r      <= ln_c;
      ld_r      <= ld_c;
      rn_r      <= rn_c;
      rd_r      <= rd_c;
      dist_ok_r <= dist_ok_c;
    end
    if (cmd.load) begin
      out_word_r.visible   <= (item_r.opcode == sfov_pkg::OP_READ) && item_in_r && seen_q;
      out_word_r.cell_open <= item_in_r &&
                              ((item_r.opcode == sfov_pkg::OP_WRITE) ?
                               item_r.see_through : clear_q);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    status.in_op      = in_word.opcode;
    status.sweep_last = sweep_last;
    status.row_end    = (f_r.dx > 0);
    status.pop        = f_r.blocked || (f_r.row >= rad);
    status.sp_one     = (sp_r == SPW'(1));
    status.oct_last   = (oct_r == 3'd7);
    status.cell_in    = in_map(px, py);
    status.out_full   = out_valid_r && out_stall;
  end

endmodule

[test/tb_shadowcast_field_of_view_core.sv]
module tb_shadowcast_field_of_view_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W   = 64;
  localparam int GRID_H   = 64;
  localparam int DEPTH    = 32;
  localparam int HANG_MAX = 200000;

  class fov_scoreboard;
    bit clear_m [GRID_W*GRID_H];
    bit seen_m [GRID_W*GRID_H];
    int radius;
    int errors;
    sfov_pkg::out_word_t pending_q [$];
    int f_row [DEPTH], f_dx [DEPTH], f_sn [DEPTH], f_sd [DEPTH];
    int f_en [DEPTH], f_ed [DEPTH], f_nn [DEPTH], f_nd [DEPTH];
    bit f_blk [DEPTH];

    function new();
      radius = sfov_pkg::RADIUS_RESET;
      errors = 0;
      foreach (clear_m[i]) begin
        clear_m[i] = 0;
        seen_m[i]  = 0;
      end
    endfunction

    function void push_scan(inout int sp, input int row, int sn, int sd, int en, int ed);
      if (sn * ed < en * sd) return;
      if (sp >= DEPTH) return;
      f_row[sp] = row; f_dx[sp] = -row;
      f_sn[sp] = sn; f_sd[sp] = sd; f_en[sp] = en; f_ed[sp] = ed;
      f_nn[sp] = 0; f_nd[sp] = 1; f_blk[sp] = 0;
      sp++;
    endfunction

    function void cast_octant(int cx, int cy, int rad, int oct);
      int sp, t, dx, dy, x, y, ln, ld, rn, rd;
      bit opaque;
      sp = 0;
      push_scan(sp, 1, 1, 1, 0, 1);
      while (sp > 0) begin
        t = sp - 1;
        if (f_dx[t] > 0) begin
          if (f_blk[t] || f_row[t] >= rad) begin
            sp--;
            continue;
          end
          f_row[t]++;
          f_dx[t] = -f_row[t];
          f_blk[t] = 0;
          continue;
        end
        dx = f_dx[t];
        dy = -f_row[t];
        f_dx[t]++;
        x = cx + dx * int'(sfov_pkg::OCT_XX[oct]) + dy * int'(sfov_pkg::OCT_XY[oct]);
        y = cy + dx * int'(sfov_pkg::OCT_YX[oct]) + dy * int'(sfov_pkg::OCT_YY[oct]);
        if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) continue;
        ln = 1 - 2 * dx;  ld = 2 * f_row[t] - 1;
        rn = -2 * dx - 1; rd = 2 * f_row[t] + 1;
        if (f_sn[t] * rd < rn * f_sd[t]) continue;
        if (f_en[t] * ld > ln * f_ed[t]) begin
          f_dx[t] = 1;
          continue;
        end
        if (dx * dx + dy * dy <= rad * rad) seen_m[x + y * GRID_W] = 1;
        opaque = (clear_m[x + y * GRID_W] == 0);
        if (f_blk[t]) begin
          if (opaque) begin
            f_nn[t] = rn; f_nd[t] = rd;
          end else begin
            f_blk[t] = 0; f_sn[t] = f_nn[t]; f_sd[t] = f_nd[t];
          end
        end else if (opaque && f_row[t] < rad) begin
          f_blk[t] = 1;
          f_nn[t] = rn; f_nd[t] = rd;
          push_scan(sp, f_row[t] + 1, f_sn[t], f_sd[t], ln, ld);
        end
      end
    endfunction

    function void note_word(sfov_pkg::in_word_t w);
      int idx, rad;
      sfov_pkg::out_word_t r;
      idx = int'(w.cell_x) + int'(w.cell_y) * GRID_W;
      r = '0;
      case (w.opcode)
        sfov_pkg::OP_WRITE: clear_m[idx] = w.see_through;
        sfov_pkg::OP_COMPUTE: begin
          rad = (radius > DEPTH) ? DEPTH : radius;
          foreach (seen_m[i]) seen_m[i] = 0;
          for (int o = 0; o < 8; o++) cast_octant(w.cell_x, w.cell_y, rad, o);
          seen_m[idx] = 1;
        end
        sfov_pkg::OP_READ: r.visible = seen_m[idx];
        default: ;
      endcase
      r.cell_open = clear_m[idx];
      pending_q = {pending_q, r};
    endfunction

    function void check_word(sfov_pkg::out_word_t o);
      sfov_pkg::out_word_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %b", o);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (o.visible !== e.visible) begin
        $error("visible: expected %b, got %b", e.visible, o.visible);
        errors++;
      end
      if (o.cell_open !== e.cell_open) begin
        $error("cell_open: expected %b, got %b", e.cell_open, o.cell_open);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  sfov_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  sfov_pkg::out_word_t out_word;
  logic cfg_we = 0;
  logic [4:0] cfg_wdata = '0;

  fov_scoreboard sb = new();
  bit quiet = 0;
  int stall_hold = 0;
  int hang_cnt = 0;
  int n_words = 0, n_computes = 0, n_reads = 0, n_results = 0;
  int cx = 32, cy = 32;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  shadowcast_field_of_view_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_word);
      n_results++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cnt = 0;
    end else begin
      hang_cnt++;
      if (hang_cnt >= HANG_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_hold <= 0) begin
      out_stall = !quiet && ($urandom_range(0, 3) == 0);
      stall_hold = out_stall ? $urandom_range(1, 14) : $urandom_range(1, 40);
    end
    stall_hold--;
    if (quiet) out_stall = 0;
  end

  task automatic send_word(sfov_pkg::op_t op, int x, int y, bit st);
    sfov_pkg::in_word_t w;
    w.opcode = op;
    w.cell_x = x[5:0];
    w.cell_y = y[5:0];
    w.see_through = st;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1;
    in_word = w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    sb.note_word(w);
    n_words++;
    if (op == sfov_pkg::OP_COMPUTE) n_computes++;
    if (op == sfov_pkg::OP_READ) n_reads++;
    @(negedge clk);
  endtask

  task automatic set_radius(int r);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = r[4:0];
    @(negedge clk);
    cfg_we = 0;
    sb.radius = r;
  endtask

  task automatic random_burst(int count);
    int dx, dy, k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      dx = cx + $urandom_range(0, 20) - 10;
      dy = cy + $urandom_range(0, 20) - 10;
      if ($urandom_range(0, 9) == 0) begin
        dx = $urandom_range(0, 63);
        dy = $urandom_range(0, 63);
      end
      if (dx < 0) dx = 0;
      if (dx > 63) dx = 63;
      if (dy < 0) dy = 0;
      if (dy > 63) dy = 63;
      if (k < 55) send_word(sfov_pkg::OP_WRITE, dx, dy, $urandom_range(0, 3) != 0);
      else if (k < 58) send_word(sfov_pkg::OP_COMPUTE, dx, dy, $urandom_range(0, 1));
      else if (k < 97) send_word(sfov_pkg::OP_READ, dx, dy, $urandom_range(0, 1));
      else send_word(sfov_pkg::OP_NONE, dx, dy, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int radii [8];
    radii = '{8, 0, 1, 31, 5, 12, 3, 20};
    repeat (6) @(negedge clk);
    rst_n = 1;

    send_word(sfov_pkg::OP_WRITE, 0, 0, 1);
    send_word(sfov_pkg::OP_WRITE, 63, 63, 1);
    send_word(sfov_pkg::OP_WRITE, 1, 1, 1);
    send_word(sfov_pkg::OP_WRITE, 62, 62, 0);
    send_word(sfov_pkg::OP_READ, 0, 0, 0);
    send_word(sfov_pkg::OP_READ, 63, 0, 1);
    send_word(sfov_pkg::OP_COMPUTE, 0, 0, 0);
    send_word(sfov_pkg::OP_READ, 0, 0, 0);
    send_word(sfov_pkg::OP_READ, 1, 1, 0);
    send_word(sfov_pkg::OP_READ, 2, 2, 0);
    send_word(sfov_pkg::OP_COMPUTE, 63, 63, 1);
    send_word(sfov_pkg::OP_READ, 63, 63, 0);
    send_word(sfov_pkg::OP_READ, 62, 62, 0);
    send_word(sfov_pkg::OP_READ, 0, 0, 0);
    send_word(sfov_pkg::OP_NONE, 63, 63, 1);
    send_word(sfov_pkg::OP_NONE, 0, 0, 0);
    send_word(sfov_pkg::OP_WRITE, 63, 63, 0);
    send_word(sfov_pkg::OP_READ, 63, 63, 1);
    send_word(sfov_pkg::OP_COMPUTE, 32, 32, 0);
    send_word(sfov_pkg::OP_READ, 33, 32, 0);

    for (int p = 0; p < 8; p++) begin
      set_radius(p < 7 ? radii[p] : $urandom_range(0, 31));
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
      if (p == 7) quiet = 1;
      random_burst(240);
      send_word(sfov_pkg::OP_COMPUTE, cx, cy, 0);
      random_burst(5);
    end
    in_valid = 0;

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d words (%0d view computes, %0d reads), %0d results checked",
             n_words, n_computes, n_reads, n_results);
    $display("radius settings 8, 0, 1, 31 and mid values, with random idling both sides");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/sfov_pkg.sv
hw/rtl/sfov_ctrl.sv
hw/rtl/sfov_dp.sv
hw/rtl/shadowcast_field_of_view_core.sv
test/tb_shadowcast_field_of_view_core.sv
